>>> design/rsa_pkg.sv
// Package: widths, command and status structs for the modular exponentiation block.
package rsa_pkg;
    localparam int unsigned WIDTH = 32;
    localparam int unsigned BIT_W = $clog2(WIDTH);
    localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(21);
    localparam logic [WIDTH-1:0] EXPONENT_RESET = WIDTH'(5);
    localparam logic ADDR_MODULUS = 1'b0;
    localparam logic ADDR_EXPONENT = 1'b1;

    typedef logic [WIDTH-1:0] t_word;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_REDUCE,
        CMD_MUL_START,
        CMD_MUL_STEP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_base;
    } t_cmd;

    typedef struct packed {
        logic reduce_done;
        logic mod_small;
    } t_status;
endpackage

>>> design/rsa_modular_exponentiation_top.sv
// Top level: APB registers, controller and datapath of the modular exponentiation block.
//
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+-----------------
//  input    | i_in_valid    | o_in_stall    | i_message
//  output   | o_out_valid   | i_out_stall   | o_result
//  config   | psel/penable  | pready (=1)   | paddr, pwdata
//
// The multiplier is shift-add, one multiplier bit per cycle. Reset is
// synchronous, active low, and restores the registers to modulus 21,
// exponent 5. One item is in flight; a new input transfer waits until
// the last result has been taken.
module rsa_modular_exponentiation_top import rsa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_word r_modulus, r_exponent, r_result, w_dp_result;
    t_cmd w_cmd;
    t_status w_status;
    logic w_capture;

    assign pready = 1'b1;

    // Write on the access phase; word address picks the register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
            r_exponent <= EXPONENT_RESET;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == ADDR_MODULUS) r_modulus <= WIDTH'(pwdata);
            else r_exponent <= WIDTH'(pwdata);
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ADDR_EXPONENT) prdata = 32'(r_exponent);
        else prdata = 32'(r_modulus);
    end

    rsa_controller u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .i_exponent(r_exponent), .i_status(w_status), .o_cmd(w_cmd), .o_capture(w_capture)
    );

    rsa_datapath u_dp (
        .i_clk, .i_cmd(w_cmd), .i_message(WIDTH'(i_message)), .i_modulus(r_modulus),
        .o_status(w_status), .o_result(w_dp_result)
    );

    // Hold the result until its transfer.
    always_ff @(posedge i_clk) begin
        if (w_capture) r_result <= w_dp_result;
    end

    assign o_result = 32'(r_result);
endmodule

>>> design/rsa_datapath.sv
// Datapath: message reduction, shift-add modular multiplier and accumulator.
module rsa_datapath import rsa_pkg::*; (
    input  logic    i_clk,
    input  t_cmd    i_cmd,
    input  t_word   i_message,
    input  t_word   i_modulus,
    output t_status o_status,
    output t_word   o_result
);
    t_word r_base, r_acc, r_prod, r_mb, r_rem, r_msg;
    logic [BIT_W:0] r_rcnt;
    logic [WIDTH:0] w_dbl, w_sum, w_rdbl;
    t_word w_after_dbl, w_after_add, w_rnext;

    // modular doubling then conditional add of the multiplicand
    always_comb begin
        w_dbl = {r_prod, 1'b0};
        w_after_dbl = (w_dbl >= {1'b0, i_modulus}) ? WIDTH'(w_dbl - {1'b0, i_modulus})
                                                    : w_dbl[WIDTH-1:0];
        w_sum = {1'b0, w_after_dbl} + {1'b0, i_cmd.sel_base ? r_base : r_acc};
        w_after_add = (w_sum >= {1'b0, i_modulus}) ? WIDTH'(w_sum - {1'b0, i_modulus})
                                                    : w_sum[WIDTH-1:0];
        w_rdbl = {r_rem, r_msg[WIDTH-1]};
        w_rnext = (w_rdbl >= {1'b0, i_modulus}) ? WIDTH'(w_rdbl - {1'b0, i_modulus})
                                                 : w_rdbl[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CMD_LOAD: begin
                r_msg  <= i_message;
                r_rem  <= '0;
                r_rcnt <= '0;
                r_prod <= WIDTH'(1);
            end
            CMD_REDUCE: begin
                // restoring remainder, one message bit per cycle
                r_rem  <= w_rnext;
                r_msg  <= {r_msg[WIDTH-2:0], 1'b0};
                r_rcnt <= r_rcnt + 1'b1;
                r_base <= w_rnext;
            end
            CMD_MUL_START: begin
                // latch the last product as multiplier and as square multiplicand
                r_prod <= '0;
                r_acc  <= r_prod;
                r_mb   <= r_prod;
            end
            CMD_MUL_STEP: begin
                r_prod <= r_mb[WIDTH-1] ? w_after_add : w_after_dbl;
                r_mb   <= {r_mb[WIDTH-2:0], 1'b0};
            end
            default: ;
        endcase
    end

    assign o_status.reduce_done = (r_rcnt == (BIT_W+1)'(WIDTH));
    assign o_status.mod_small   = (i_modulus < WIDTH'(2));
    assign o_result = o_status.mod_small ? '0 : r_prod;
endmodule

>>> design/rsa_controller.sv
// Controller: sequences reduction, squaring and multiplication over exponent bits.
module rsa_controller import rsa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_word   i_exponent,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_capture
);
    typedef enum logic [2:0] {
        S_IDLE, S_REDUCE, S_SQ_START, S_SQ, S_ML_START, S_ML, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [BIT_W-1:0] r_ebit, r_step;
    logic r_last;
    logic r_out_valid;

    // The multiplier works in place: squaring uses the acc copy of the product as
    // multiplicand and writes the product back; multiply uses the stored copy against base.
    always_comb begin
        n_state = r_state;
        o_cmd.op = CMD_NONE;
        o_cmd.sel_base = 1'b0;
        o_capture = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_in_valid && !r_out_valid) begin
                o_cmd.op = CMD_LOAD;
                n_state = S_REDUCE;
            end
            S_REDUCE: begin
                if (i_status.reduce_done) n_state = S_SQ_START;
                else o_cmd.op = CMD_REDUCE;
            end
            S_SQ_START: begin
                o_cmd.op = CMD_MUL_START;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = CMD_MUL_STEP;
                if (r_last) begin
                    if (i_exponent[r_ebit]) n_state = S_ML_START;
                    else if (r_ebit == '0) n_state = S_DONE;
                    else n_state = S_SQ_START;
                end
            end
            S_ML_START: begin
                o_cmd.op = CMD_MUL_START;
                n_state = S_ML;
            end
            S_ML: begin
                o_cmd.op = CMD_MUL_STEP;
                o_cmd.sel_base = 1'b1;
                if (r_last) n_state = (r_ebit == '0) ? S_DONE : S_SQ_START;
            end
            S_DONE: begin
                o_capture = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ebit <= '1;
            r_step <= '0;
            r_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_capture) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            if (o_cmd.op == CMD_LOAD) r_ebit <= '1;
            if (o_cmd.op == CMD_MUL_START) begin
                r_step <= '0;
                r_last <= 1'b0;
            end else if (o_cmd.op == CMD_MUL_STEP) begin
                r_step <= r_step + 1'b1;
                r_last <= (r_step == BIT_W'(WIDTH - 2));
                if (r_last) begin
                    if ((r_state == S_ML) || !i_exponent[r_ebit]) r_ebit <= r_ebit - 1'b1;
                end
            end
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
endmodule

>>> tb/tb_rsa_modular_exponentiation_top.sv
// Testbench for the modular exponentiation block: directed table, random traffic, self-check.
`timescale 1ns / 1ps
module tb_rsa_modular_exponentiation_top;
    import rsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int LONG_HOLD = 5000;
    localparam logic [2:0] REG_MODULUS = 3'(4 * ADDR_MODULUS);
    localparam logic [2:0] REG_EXPONENT = 3'(4 * ADDR_EXPONENT);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_message = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rsa_modular_exponentiation_top uut (.*);

    // Free-running clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Local copy of the key registers, updated with every register write.
    t_word key_modulus = MODULUS_RESET;
    t_word key_exponent = EXPONENT_RESET;

    t_word pending_results[$];
    int    mismatches = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    recv_hold = 1'b0;
    event  start_hold;

    // Directed rows: configuration, message, and a hand-checked result where obvious.
    typedef struct {
        t_word modulus;
        t_word exponent;
        t_word message;
        bit    known;
        t_word result;
    } t_row;

    t_row directed_rows[] = '{
        '{32'd21, 32'd5, 32'd0, 1'b1, 32'd0},
        '{32'd21, 32'd5, 32'd1, 1'b1, 32'd1},
        '{32'd21, 32'd5, 32'd21, 1'b1, 32'd0},          // message equal to modulus
        '{32'd21, 32'd5, 32'd22, 1'b1, 32'd1},          // message above modulus
        '{32'd21, 32'd5, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{32'd21, 32'd0, 32'd0, 1'b1, 32'd1},           // zero exponent, zero message
        '{32'd21, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001, 1'b0, 32'd0},
        '{32'hFFFF_FFFF, 32'd1, 32'h1234_5678, 1'b1, 32'h1234_5678},
        '{32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1},
        '{32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'd0},
        '{32'd1, 32'd7, 32'd5, 1'b1, 32'd0},            // modulus one
        '{32'd1, 32'd0, 32'd5, 1'b1, 32'd0},
        '{32'd0, 32'd3, 32'hFFFF_FFFF, 1'b1, 32'd0},    // modulus zero
        '{32'd3233, 32'd17, 32'd65, 1'b1, 32'd2790},    // textbook key pair
        '{32'd3233, 32'd2753, 32'd2790, 1'b1, 32'd65},
        '{32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'd0}
    };

    // Square and multiply over all 32 exponent bits with exact 64-bit products.
    function automatic t_word modexp(t_word msg, t_word expo, t_word n);
        logic [63:0] acc;
        logic [63:0] base;
        if (n < 2) return '0;
        base = 64'(msg) % 64'(n);
        acc = 64'd1;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            acc = (acc * acc) % 64'(n);
            if (expo[i]) acc = (acc * base) % 64'(n);
        end
        return t_word'(acc);
    endfunction

    // One APB write: setup cycle, then access cycle. Called at a falling edge.
    task automatic write_reg(logic [2:0] addr, t_word data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == REG_MODULUS) key_modulus = data;
        else key_exponent = data;
    endtask

    // Hold until every result is back, then let the block settle.
    task automatic drain();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_key(t_word n, t_word e);
        drain();
        write_reg(REG_MODULUS, n);
        write_reg(REG_EXPONENT, e);
    endtask

    // Offer one message and hold it until the transfer happens. Entered at a falling edge.
    task automatic send_message(t_word msg, bit known, t_word result);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_message = msg;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(known ? result : modexp(msg, key_exponent, key_modulus));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic t_word random_message();
        case ($urandom_range(5))
            0: return '0;
            1: return key_modulus - 1;
            2: return (key_modulus > 1) ? $urandom_range(key_modulus - 1) : '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_word random_modulus();
        case ($urandom_range(3))
            0: return $urandom_range(2, 1000);
            1: return $urandom | 32'h8000_0001;
            default: return $urandom | 32'd2;
        endcase
    endfunction

    function automatic t_word random_exponent();
        case ($urandom_range(3))
            0: return $urandom_range(0, 70000);
            1: return $urandom & 32'h0000_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Output side: drop stall at random, or hold it high through a long stretch.
    always @(negedge i_clk) begin
        i_out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
    end

    always begin
        @(start_hold);
        recv_hold = 1'b1;
        repeat (LONG_HOLD) @(negedge i_clk);
        recv_hold = 1'b0;
    end

    // Compare each result transfer with the oldest pending prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: result=%h", o_result);
                mismatches++;
            end else begin
                t_word want;
                want = pending_results.pop_front();
                if (o_result !== want) begin
                    $error("result: expected %h, actual %h", want, o_result);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing transfers for too long.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table; registers still hold reset values for the first rows.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].modulus != key_modulus ||
                directed_rows[i].exponent != key_exponent) begin
                set_key(directed_rows[i].modulus, directed_rows[i].exponent);
            end
            send_message(directed_rows[i].message, directed_rows[i].known,
                         directed_rows[i].result);
        end

        // Random phases: sender idles little, then receiver idles little, then neither.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 52 : 0;
            recv_stall_pct = (mode == 0) ? 52 : (mode == 1) ? 8 : 0;
            for (int k = 0; k < 3; k++) begin
                set_key(random_modulus(), random_exponent());
                if (mode == 2 && k == 0) ->start_hold;   // block fills, input stalls
                for (int j = 0; j < 28; j++) begin
                    if (j == 14 && k == 1) drain();     // sender waits for all results
                    send_message(random_message(), 1'b0, '0);
                end
            end
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
